[src/dme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_pkg: shared types and constants of the one-bit delta modulation encoder
// Input, result and configuration words, plus the sequencer state encoding.
// ----------------------------------------------------------------------------
package dme_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 20;
  localparam int BYTE_W   = 8;

  // step register after reset: 1.0 in Q4.16
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

  // input word: one sample of the chosen channel
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_word_t;

  // result word: one packed byte of delta bits
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] start_level;
    logic              last_byte;
  } out_word_t;

  // configuration word: step register write data
  typedef logic [STEP_W-1:0] cfg_word_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BIT   = 4'b0010,
    ST_PAD   = 4'b0100,
    ST_FINAL = 4'b1000
  } state_t;

endpackage

[src/dme_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_chan_if: valid/ready channel
// Carries one word of type T per handshake; source drives, sink accepts.
// ----------------------------------------------------------------------------
interface dme_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[src/one_bit_delta_modulation_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_bit_delta_modulation_encoder: resampling one-bit delta encoder
// Turns signed 16-bit samples into a packed stream of delta bits.
// ----------------------------------------------------------------------------
// Each accepted sample is worked by a small sequencer around one shared
// position adder, one output bit per cycle while the output register takes
// its bytes: ST_IDLE accepts the sample, then ST_BIT makes the output bits
// (0 to 8 at a step of 1/8 or more) and closes the position. The sample marked
// last is followed by padding in ST_PAD, one zero bit per cycle under the same
// hold, up to the end of the current block of 8*PAD_BYTES bits; ST_PAD then
// sees the block end and ST_FINAL sends the final byte. Every cycle that needs
// to hand a byte to the output register waits while that register is still
// full. in_ready is high only while the sequencer is idle. The step register
// (Q4.16, values below 1/8 act as 1/8) may be written at any idle time.

module one_bit_delta_modulation_encoder #(
  parameter int PAD_BYTES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dme_chan_if.sink   in_ch,
  dme_chan_if.source out_ch,
  dme_chan_if.sink   cfg_ch
);

  localparam int STEP_W     = dme_pkg::STEP_W;
  localparam int SAMPLE_W   = dme_pkg::SAMPLE_W;
  localparam int BYTE_W     = dme_pkg::BYTE_W;
  localparam int POS_W      = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int BLOCK_BITS = PAD_BYTES * 8;
  localparam int BIDX_W     = $clog2(BLOCK_BITS);

  localparam logic [POS_W-1:0]  ONE_POS   = {{(POS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [POS_W-1:0]  MIN_STEP  = {{(POS_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 3);
  localparam logic [POS_W-1:0]  NEG_ONE   = ~ONE_POS + {{(POS_W-1){1'b0}}, 1'b1};
  localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(BLOCK_BITS - 1);

  // sequencer and stream state
  dme_pkg::state_t             state_r, state_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic signed [SAMPLE_W-1:0]  prev_sample_r, prev_sample_nxt;
  logic                        prev_bit_r, prev_bit_nxt;
  logic [BIDX_W-1:0]           bit_idx_r, bit_idx_nxt;
  logic [BYTE_W-1:0]           shift_r, shift_nxt;
  logic [BYTE_W-1:0]           level_r, level_nxt;
  logic                        first_seen_r, first_seen_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // current sample, no reset
  logic signed [SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic                        last_r, last_nxt;
  logic                        had_bits_r, had_bits_nxt;
  dme_pkg::out_word_t          out_word_r, out_word_nxt;

  // datapath signals
  logic [POS_W-1:0]  step_ext;
  logic [POS_W-1:0]  step_eff;
  logic [POS_W-1:0]  addend;
  logic [POS_W-1:0]  pos_sum;
  logic              pos_lt_one;
  logic              delta_bit;
  logic              out_free;
  logic              byte_done;
  logic [BIDX_W-1:0] bit_idx_inc;
  logic [2:0]        bit_pos;

  // handshake outputs
  assign in_ch.ready  = (state_r == dme_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // shared position adder: add the step inside the bit loop, drop one frame at its end
  assign step_ext   = {{(POS_W-STEP_W){1'b0}}, step_r};
  assign step_eff   = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
  assign pos_lt_one = (pos_r < ONE_POS);
  assign addend     = pos_lt_one ? step_eff : NEG_ONE;
  assign pos_sum    = pos_r + addend;

  // delta decision against the sample of the previous bit
  always_comb begin
    priority if (sample_r < prev_sample_r) begin
      delta_bit = 1'b0;
    end else if (sample_r > prev_sample_r) begin
      delta_bit = 1'b1;
    end else begin
      delta_bit = ~prev_bit_r;
    end
  end

  // bit counter within the block, byte boundary detect
  assign bit_pos     = bit_idx_r[2:0];
  assign byte_done   = (bit_pos == 3'd0);
  assign bit_idx_inc = (bit_idx_r == BIDX_LAST) ? '0 : bit_idx_r + {{(BIDX_W-1){1'b0}}, 1'b1};
  assign out_free    = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    pos_nxt         = pos_r;
    prev_sample_nxt = prev_sample_r;
    prev_bit_nxt    = prev_bit_r;
    bit_idx_nxt     = bit_idx_r;
    shift_nxt       = shift_r;
    level_nxt       = level_r;
    first_seen_nxt  = first_seen_r;
    sample_nxt      = sample_r;
    last_nxt        = last_r;
    had_bits_nxt    = had_bits_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_word_nxt    = out_word_r;

    // step register write
    if (cfg_ch.valid) begin
      step_nxt = cfg_ch.data;
    end

    unique case (state_r)
      dme_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt   = in_ch.data.sample;
          last_nxt     = in_ch.data.last_sample;
          had_bits_nxt = first_seen_r;
          if (!first_seen_r) begin
            level_nxt      = {~in_ch.data.sample[SAMPLE_W-1], in_ch.data.sample[SAMPLE_W-2:8]};
            first_seen_nxt = 1'b1;
          end
          state_nxt = dme_pkg::ST_BIT;
        end
      end

      dme_pkg::ST_BIT: begin
        priority if (!pos_lt_one) begin
          // loop ends: step back one frame
          pos_nxt   = pos_sum;
          state_nxt = last_r ? dme_pkg::ST_PAD : dme_pkg::ST_IDLE;
        end else if (last_r && had_bits_r && (bit_idx_r == '0)) begin
          // block full on the last sample: drop the rest
          state_nxt = dme_pkg::ST_PAD;
        end else if (!(had_bits_r && byte_done) || out_free) begin
          if (had_bits_r && byte_done) begin
            out_valid_nxt          = 1'b1;
            out_word_nxt.data_byte = shift_r;
            out_word_nxt.start_level = level_r;
            out_word_nxt.last_byte = 1'b0;
            shift_nxt              = '0;
          end
          shift_nxt[bit_pos] = delta_bit;
          bit_idx_nxt        = bit_idx_inc;
          had_bits_nxt       = 1'b1;
          prev_sample_nxt    = sample_r;
          prev_bit_nxt       = delta_bit;
          pos_nxt            = pos_sum;
        end
      end

      dme_pkg::ST_PAD: begin
        if (bit_idx_r == '0) begin
          state_nxt = dme_pkg::ST_FINAL;
        end else if (!byte_done || out_free) begin
          if (byte_done) begin
            out_valid_nxt            = 1'b1;
            out_word_nxt.data_byte   = shift_r;
            out_word_nxt.start_level = level_r;
            out_word_nxt.last_byte   = 1'b0;
            shift_nxt                = '0;
          end
          shift_nxt[bit_pos] = 1'b0;
          bit_idx_nxt        = bit_idx_inc;
        end
      end

      dme_pkg::ST_FINAL: begin
        // final byte, then the stream starts over
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.data_byte   = shift_r;
          out_word_nxt.start_level = level_r;
          out_word_nxt.last_byte   = 1'b1;
          pos_nxt                  = '0;
          prev_sample_nxt          = '0;
          prev_bit_nxt             = 1'b0;
          bit_idx_nxt              = '0;
          shift_nxt                = '0;
          level_nxt                = '0;
          first_seen_nxt           = 1'b0;
          state_nxt                = dme_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dme_pkg::ST_IDLE;
      end
    endcase
  end

  // control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dme_pkg::ST_IDLE;
      step_r        <= dme_pkg::STEP_RESET;
      pos_r         <= '0;
      prev_sample_r <= '0;
      prev_bit_r    <= 1'b0;
      bit_idx_r     <= '0;
      shift_r       <= '0;
      level_r       <= '0;
      first_seen_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      pos_r         <= pos_nxt;
      prev_sample_r <= prev_sample_nxt;
      prev_bit_r    <= prev_bit_nxt;
      bit_idx_r     <= bit_idx_nxt;
      shift_r       <= shift_nxt;
      level_r       <= level_nxt;
      first_seen_r  <= first_seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // working sample and output word
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    had_bits_r <= had_bits_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[src/dme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_checker: port-level checks of the delta modulation encoder
// Watches the channel handshakes over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module dme_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_start_level,
  input logic       out_last_byte,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_start_level) && $stable(out_last_byte))
    else $error("result word changed while stalled");

  // an accepted sample drops in_ready while it is worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while busy");

  // step register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // no result word right out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind one_bit_delta_modulation_encoder dme_checker u_dme_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_data_byte   (out_ch.data.data_byte),
  .out_start_level (out_ch.data.start_level),
  .out_last_byte   (out_ch.data.last_byte),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready)
);

[tb/one_bit_delta_modulation_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_bit_delta_modulation_encoder_tb: self-checking bench for the delta encoder
// Drives sample words and step register writes with random gaps, predicts
// every packed byte word in a behavioral encoder and compares each received
// word field by field. A directed table runs first, then a stream that
// overflows a padding block, then random streams at random steps.
// ----------------------------------------------------------------------------
module one_bit_delta_modulation_encoder_tb;

  localparam logic [31:0] ONE_POS   = 32'h0001_0000;
  localparam logic [31:0] MIN_STEP  = 32'h0000_2000;
  localparam int          PAD_BYTES = 64;
  localparam int          SETTLE    = 16;
  localparam int          RAND_ITEMS = 45;

  // one row of the directed table
  typedef struct packed {
    logic               set_step;
    logic [19:0]        step;
    logic signed [15:0] smp;
    logic               lst;
    logic               typed;
    logic [6:0]         n;
    logic [7:0]         b0;
    logic [7:0]         lvl;
  } vec_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  dme_chan_if #(.T(dme_pkg::in_word_t))  in_ch  ();
  dme_chan_if #(.T(dme_pkg::out_word_t)) out_ch ();
  dme_chan_if #(.T(dme_pkg::cfg_word_t)) cfg_ch ();

  one_bit_delta_modulation_encoder #(
    .PAD_BYTES(PAD_BYTES),
    .FRAC_BITS(16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // behavioral encoder state
  logic [19:0]        step_reg;
  logic [31:0]        pos_acc;
  logic signed [15:0] prev_smp;
  logic               prev_bit;
  logic [8:0]         bit_pos;
  logic [7:0]         byte_acc;
  logic [7:0]         lvl;
  logic               started;
  int                 n_burst;
  bit                 keep_pred;

  // expected byte words and bookkeeping
  dme_pkg::out_word_t byte_q[$];
  vec_row_t  vec_q[$];
  int        pending    = 0;
  int        errors     = 0;
  int        bytes_seen = 0;
  bit        no_idle    = 1'b0;

  task automatic report_err(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic [7:0] l, input logic fin);
    dme_pkg::out_word_t o;
    o.data_byte   = b;
    o.start_level = l;
    o.last_byte   = fin;
    byte_q.push_back(o);
    pending++;
  endtask

  task automatic clear_stream_model();
    pos_acc  = '0;
    prev_smp = '0;
    prev_bit = 1'b0;
    bit_pos  = '0;
    byte_acc = '0;
    lvl      = '0;
    started  = 1'b0;
  endtask

  // at most PAD_BYTES words per accepted sample
  task automatic emit_byte(input logic [7:0] b, input logic fin);
    if (n_burst < PAD_BYTES) begin
      if (keep_pred) push_byte(b, lvl, fin);
      n_burst++;
    end
  endtask

  // a complete byte is held until the next bit of the stream arrives
  task automatic add_bit(input logic had, input logic b);
    if (had && bit_pos[2:0] == 3'd0) begin
      emit_byte(byte_acc, 1'b0);
      byte_acc = '0;
    end
    byte_acc[bit_pos[2:0]] = byte_acc[bit_pos[2:0]] | b;
    bit_pos = bit_pos + 9'd1;
  endtask

  // expected words caused by one accepted sample
  task automatic encode_sample(input dme_pkg::in_word_t w);
    logic [31:0]        eff;
    logic signed [15:0] smp;
    logic               had;
    logic               stop;
    logic               b;
    eff     = (step_reg < MIN_STEP) ? MIN_STEP : {12'd0, step_reg};
    smp     = w.sample;
    had     = started;
    stop    = 1'b0;
    n_burst = 0;
    if (!started) begin
      lvl     = {~w.sample[15], w.sample[14:8]};
      started = 1'b1;
    end
    // one bit per output point on this sample; a last sample stops at a block edge
    while (pos_acc < ONE_POS && !stop) begin
      if (w.last_sample && had && bit_pos == 9'd0) begin
        stop = 1'b1;
      end else begin
        if (smp < prev_smp) b = 1'b0;
        else if (smp > prev_smp) b = 1'b1;
        else b = ~prev_bit;
        add_bit(had, b);
        had      = 1'b1;
        prev_smp = smp;
        prev_bit = b;
        pos_acc  = pos_acc + eff;
      end
    end
    if (pos_acc >= ONE_POS) pos_acc = pos_acc - ONE_POS;
    // zero padding to the block edge, final byte flagged, new stream
    if (w.last_sample) begin
      while (bit_pos != 9'd0) add_bit(1'b1, 1'b0);
      emit_byte(byte_acc, 1'b1);
      clear_stream_model();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // offer one sample word, then predict at acceptance
  task automatic send_word(input logic signed [15:0] s, input logic l, input logic typed,
                           input int n, input logic [7:0] b0, input logic [7:0] lv);
    dme_pkg::in_word_t w;
    int       gap;
    w.sample      = s;
    w.last_sample = l;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    keep_pred = !typed;
    encode_sample(w);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        push_byte((i == 0) ? b0 : 8'h00, lv, l && (i == n - 1));
      end
    end
  endtask

  // input off, all words back, then let the sequencer finish
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_step(input logic [19:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    step_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_row(input int set, input logic [19:0] st, input logic signed [15:0] s,
                         input int l, input int typed, input int n,
                         input logic [7:0] b0, input logic [7:0] lv);
    vec_row_t row;
    row.set_step = (set != 0);
    row.step     = st;
    row.smp      = s;
    row.lst      = (l != 0);
    row.typed    = (typed != 0);
    row.n        = n[6:0];
    row.b0       = b0;
    row.lvl      = lv;
    vec_q.push_back(row);
  endtask

  // compare each received word with the oldest expectation
  always @(posedge clk) begin : collect
    dme_pkg::out_word_t got;
    dme_pkg::out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      bytes_seen++;
      if (pending == 0) begin
        report_err($sformatf("unexpected word byte=%h level=%h last=%b",
                             got.data_byte, got.start_level, got.last_byte));
      end else begin
        want = byte_q.pop_front();
        pending--;
        if (got.data_byte !== want.data_byte)
          report_err($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
        if (got.start_level !== want.start_level)
          report_err($sformatf("start_level got %h want %h",
                               got.start_level, want.start_level));
        if (got.last_byte !== want.last_byte)
          report_err($sformatf("last_byte got %b want %b", got.last_byte, want.last_byte));
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the input
  initial begin : recv
    int stall_left;
    int r;
    bit pressed;
    stall_left   = 0;
    pressed      = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && bytes_seen >= 30) begin
        pressed    = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(19, 59);
        end
      end
    end
  end

  // run limit
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin : stim
    vec_row_t           row;
    logic signed [15:0] s;
    logic signed [15:0] last_sent;
    logic [19:0]        st;
    int                 n_rand;
    int                 len;
    int                 r;
    bit                 ends;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    step_reg     = dme_pkg::STEP_RESET;
    keep_pred    = 1'b1;
    clear_stream_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: typed rows give their expected words directly, rest predicted
    add_row(1, 20'd65536,   -16'sd32768, 1, 1, 64, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd32767, 1, 1, 64, 8'h01, 8'hff);
    add_row(0, 20'd0,        16'sd0,     1, 1, 64, 8'h01, 8'h80);
    add_row(1, 20'd8192,     16'sd32767, 1, 1, 64, 8'h55, 8'hff);
    // small step, zero included, acts as 1/8
    add_row(1, 20'd0,       -16'sd1,     1, 1, 64, 8'haa, 8'h7f);
    add_row(1, 20'd8191,    -16'sd32768, 1, 1, 64, 8'haa, 8'h00);
    // largest step: one bit, then samples that make no bits
    add_row(1, 20'hfffff,    16'sd100,   0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd32768, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd32767, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd0,     1, 1, 64, 8'h01, 8'h80);
    // unit step with equal neighbors and extremes
    add_row(1, 20'd65536,    16'sd0,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd0,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd5,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd5,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd5,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd32767, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd32767, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd32768, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd32768, 0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd1234,  1, 0, 0, 8'h00, 8'h00);
    // step of 1.5: samples skipped now and then
    add_row(1, 20'd98304,    16'sd7,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd7,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd7,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,       -16'sd7,     0, 0, 0, 8'h00, 8'h00);
    add_row(0, 20'd0,        16'sd300,   1, 0, 0, 8'h00, 8'h00);

    for (int i = 0; i < vec_q.size(); i++) begin
      row = vec_q[i];
      if (row.set_step) write_step(row.step);
      send_word(row.smp, row.lst, row.typed, int'(row.n), row.b0, row.lvl);
    end

    // block overflow on the last sample: 505 bits, then a sample with 8 bits
    write_step(20'd8192);
    for (int i = 0; i < 63; i++) begin
      s = 16'($urandom_range(0, 65535));
      send_word(s, 1'b0, 1'b0, 0, 8'h00, 8'h00);
    end
    write_step(20'd65536);
    s = 16'($urandom_range(0, 65535));
    send_word(s, 1'b0, 1'b0, 0, 8'h00, 8'h00);
    write_step(20'd8192);
    s = 16'($urandom_range(0, 65535));
    send_word(s, 1'b1, 1'b0, 0, 8'h00, 8'h00);

    // random streams, most of them closed by a last sample
    n_rand    = 0;
    last_sent = '0;
    while (n_rand < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 5) st = 20'($urandom_range(8192, 98304));
      else if (r < 7) st = 20'($urandom_range(0, 1048575));
      else if (r < 8) st = 20'd8192;
      else st = 20'($urandom_range(98304, 262144));
      write_step(st);
      no_idle = ($urandom_range(0, 4) == 0);
      len     = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      ends    = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 5) s = 16'($urandom_range(0, 65535));
        else if (r < 8) s = last_sent + 16'($urandom_range(0, 4)) - 16'sd2;
        else s = last_sent;
        last_sent = s;
        send_word(s, ends && (k == len - 1), 1'b0, 0, 8'h00, 8'h00);
        n_rand++;
      end
    end
    no_idle = 1'b0;

    wait_quiet();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
